@@ hdl/tenf_pkg.sv @@
package tenf_pkg;

    // Hash constants; the datapath uses only the low bits that address the table.
    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV_PRIME = 64'h00000100000001B3;

    // Saturation limit of the whole-mesh boundary count.
    localparam logic [11:0] TOTAL_MAX = 12'hFFF;

    // Item codes on the action field.
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_READ = 1'b1;

    // Edge numbers.
    localparam logic [1:0] EDGE_BC = 2'd0;
    localparam logic [1:0] EDGE_CA = 2'd1;
    localparam logic [1:0] EDGE_AB = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_L_STORE,
        S_L_EDGE,
        S_L_HASHB,
        S_L_PROBE,
        S_L_CHECK,
        S_L_NEXT,
        S_B_START,
        S_B_TRD,
        S_B_TCAP,
        S_B_HASHA,
        S_B_HASHB,
        S_B_PROBE,
        S_B_CHECK,
        S_B_EEND,
        S_B_TEND,
        S_R_WAIT,
        S_R_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic cap_in;
        logic cap_rd;
        logic store_tri;
        logic set_ovf;
        logic cap_tri;
        logic hash_a;
        logic hash_b;
        logic idx_inc;
        logic insert;
        logic record;
        logic edge_inc;
        logic bc_inc;
        logic b_init;
        logic tri_end;
        logic tri_inc;
        logic set_done;
        logic out_load;
    } ctl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic tab_full;
        logic tab_used;
        logic step_last;
        logic cnt_full;
        logic cnt_zero;
        logic last_flag;
        logic edge_last;
        logic tri_last;
        logic done;
        logic out_free;
    } sts_t;

endpackage

@@ hdl/triangle_edge_neighbour_finder_core.sv @@
// Triangle edge-neighbour finder. After reset the edge hash table is cleared one slot a
// cycle (HASH_SLOTS slots, 16384 by default) before the first transfer is accepted. A
// load stores the triangle and then, per edge, hashes the ordered node pair in two
// rounds and, unless the table is full, probes from that slot to the first free one,
// where the edge is written. The load marked last starts the neighbour search, which
// reads back each triangle and, per edge, hashes the pair and probes its chain for a
// match. A read delivers one result transfer; total_boundaries and load_overflow give
// the values at the time of the read. Node ids use their low NODE_BITS bits.
module triangle_edge_neighbour_finder_core import tenf_pkg::*; #(
    parameter int MAX_TRIANGLES = 1024,
    parameter int HASH_SLOTS    = 16384,
    parameter int NODE_BITS     = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               action,
    input  logic [15:0]        node_a,
    input  logic [15:0]        node_b,
    input  logic [15:0]        node_c,
    input  logic               last_triangle,
    input  logic [9:0]         read_index,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               result_valid,
    output logic signed [10:0] neighbour_0,
    output logic signed [10:0] neighbour_1,
    output logic signed [10:0] neighbour_2,
    output logic signed [2:0]  neighbour_edge_0,
    output logic signed [2:0]  neighbour_edge_1,
    output logic signed [2:0]  neighbour_edge_2,
    output logic [1:0]         open_edge_count,
    output logic [11:0]        total_boundaries,
    output logic               load_overflow
);

    ctl_t ctl;
    sts_t sts;

    // Sequencing of clear, load, search and read.
    tenf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .in_stall (in_stall),
        .sts      (sts),
        .ctl      (ctl)
    );

    // Hashing, memories and result registers.
    tenf_dp #(
        .MAX_TRIANGLES (MAX_TRIANGLES),
        .HASH_SLOTS    (HASH_SLOTS),
        .NODE_BITS     (NODE_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .sts              (sts),
        .node_a           (node_a),
        .node_b           (node_b),
        .node_c           (node_c),
        .last_triangle    (last_triangle),
        .read_index       (read_index),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .result_valid     (result_valid),
        .neighbour_0      (neighbour_0),
        .neighbour_1      (neighbour_1),
        .neighbour_2      (neighbour_2),
        .neighbour_edge_0 (neighbour_edge_0),
        .neighbour_edge_1 (neighbour_edge_1),
        .neighbour_edge_2 (neighbour_edge_2),
        .open_edge_count  (open_edge_count),
        .total_boundaries (total_boundaries),
        .load_overflow    (load_overflow)
    );

endmodule

@@ hdl/tenf_ram.sv @@
module tenf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/tenf_ctrl.sv @@
module tenf_ctrl import tenf_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic action,
    output logic in_stall,
    input  sts_t sts,
    output ctl_t ctl
);

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:   if (sts.clr_last) state_next = S_IDLE;
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_READ)
                    begin
                        state_next = S_R_WAIT;
                    end
                    else if (!sts.done)
                    begin
                        state_next = S_L_STORE;
                    end
                end
            end
            S_L_STORE:
            begin
                if (sts.cnt_full)
                begin
                    state_next = sts.last_flag ? S_B_START : S_IDLE;
                end
                else
                begin
                    state_next = S_L_EDGE;
                end
            end
            S_L_EDGE:  state_next = sts.tab_full ? S_L_NEXT : S_L_HASHB;
            S_L_HASHB: state_next = S_L_PROBE;
            S_L_PROBE: state_next = S_L_CHECK;
            S_L_CHECK: state_next = sts.tab_used ? S_L_PROBE : S_L_NEXT;
            S_L_NEXT:
            begin
                if (!sts.edge_last)
                begin
                    state_next = S_L_EDGE;
                end
                else
                begin
                    state_next = sts.last_flag ? S_B_START : S_IDLE;
                end
            end
            S_B_START: state_next = sts.cnt_zero ? S_IDLE : S_B_TRD;
            S_B_TRD:   state_next = S_B_TCAP;
            S_B_TCAP:  state_next = S_B_HASHA;
            S_B_HASHA: state_next = S_B_HASHB;
            S_B_HASHB: state_next = S_B_PROBE;
            S_B_PROBE: state_next = S_B_CHECK;
            S_B_CHECK:
            begin
                if (sts.tab_used && !sts.step_last)
                begin
                    state_next = S_B_PROBE;
                end
                else
                begin
                    state_next = S_B_EEND;
                end
            end
            S_B_EEND:  state_next = sts.edge_last ? S_B_TEND : S_B_HASHA;
            S_B_TEND:  state_next = sts.tri_last ? S_IDLE : S_B_TRD;
            S_R_WAIT:  state_next = S_R_OUT;
            S_R_OUT:   if (sts.out_free) state_next = S_IDLE;
            default:   state_next = S_CLEAR;
        endcase
    end

    // Commands.
    always_comb
    begin
        ctl = '0;
        case (state_reg)
            S_CLEAR:   ctl.clr_step = 1'b1;
            S_IDLE:
            begin
                ctl.cap_in = accept && (action == ACT_LOAD);
                ctl.cap_rd = accept && (action == ACT_READ);
            end
            S_L_STORE:
            begin
                ctl.set_ovf   = sts.cnt_full;
                ctl.store_tri = !sts.cnt_full;
            end
            S_L_EDGE:  ctl.hash_a = 1'b1;
            S_L_HASHB: ctl.hash_b = 1'b1;
            S_L_PROBE: ctl      = '0;
            S_L_CHECK:
            begin
                ctl.idx_inc = sts.tab_used;
                ctl.insert  = !sts.tab_used;
            end
            S_L_NEXT:  ctl.edge_inc = !sts.edge_last;
            S_B_START:
            begin
                ctl.b_init   = 1'b1;
                ctl.set_done = sts.cnt_zero;
            end
            S_B_TRD:   ctl      = '0;
            S_B_TCAP:  ctl.cap_tri = 1'b1;
            S_B_HASHA: ctl.hash_a = 1'b1;
            S_B_HASHB: ctl.hash_b = 1'b1;
            S_B_PROBE: ctl      = '0;
            S_B_CHECK:
            begin
                ctl.record  = 1'b1;
                ctl.idx_inc = sts.tab_used && !sts.step_last;
            end
            S_B_EEND:
            begin
                ctl.bc_inc   = 1'b1;
                ctl.edge_inc = !sts.edge_last;
            end
            S_B_TEND:
            begin
                ctl.tri_end  = 1'b1;
                ctl.tri_inc  = !sts.tri_last;
                ctl.set_done = sts.tri_last;
            end
            S_R_WAIT:  ctl      = '0;
            S_R_OUT:   ctl.out_load = sts.out_free;
            default:   ctl      = '0;
        endcase
    end

endmodule

@@ hdl/tenf_dp.sv @@
module tenf_dp import tenf_pkg::*; #(
    parameter int MAX_TRIANGLES = 1024,
    parameter int HASH_SLOTS    = 16384,
    parameter int NODE_BITS     = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ctl_t               ctl,
    output sts_t               sts,
    input  logic [15:0]        node_a,
    input  logic [15:0]        node_b,
    input  logic [15:0]        node_c,
    input  logic               last_triangle,
    input  logic [9:0]         read_index,
    input  logic               out_stall,
    output logic               out_valid,
    output logic               result_valid,
    output logic signed [10:0] neighbour_0,
    output logic signed [10:0] neighbour_1,
    output logic signed [10:0] neighbour_2,
    output logic signed [2:0]  neighbour_edge_0,
    output logic signed [2:0]  neighbour_edge_1,
    output logic signed [2:0]  neighbour_edge_2,
    output logic [1:0]         open_edge_count,
    output logic [11:0]        total_boundaries,
    output logic               load_overflow
);

    localparam int KW = $clog2(HASH_SLOTS);
    localparam int TW = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
    localparam int CW = $clog2(MAX_TRIANGLES + 1);
    localparam int NW = (NODE_BITS < 16) ? NODE_BITS : 16;
    localparam int EW = 1 + 2 * NW + TW + 2;
    localparam int FW = 1 + TW + 2;
    localparam int BW = 3 * FW + 2;
    localparam logic [KW-1:0] BASIS_K = FNV_BASIS[KW-1:0];
    localparam logic [KW-1:0] PRIME_K = FNV_PRIME[KW-1:0];
    localparam logic [KW-1:0] SLOT_LAST = KW'(HASH_SLOTS - 1);

    logic [NW-1:0]   a_reg, b_reg, c_reg, lo_reg, hi_reg;
    logic [TW-1:0]   tri_reg;
    logic [1:0]      edge_reg;
    logic            last_reg;
    logic [KW-1:0]   h_reg, idx_reg, step_reg, clr_reg;
    logic [KW:0]     fill_reg;
    logic [CW-1:0]   cnt_reg;
    logic [11:0]     total_reg;
    logic            done_reg, ovf_reg;
    logic [1:0]      bc_reg;
    logic            nbf_reg [3];
    logic [TW-1:0]   nbt_reg [3];
    logic [1:0]      nbe_reg [3];
    logic [TW-1:0]   rd_addr_reg;
    logic            ok_reg;
    logic            out_valid_reg;
    logic            res_ok_reg;
    logic [10:0]     nb_out_reg [3];
    logic [2:0]      ne_out_reg [3];
    logic [1:0]      bc_out_reg;
    logic [11:0]     total_out_reg;
    logic            ovf_out_reg;

    logic [NW-1:0]   p_n, q_n, lo_next, hi_next;
    logic [31:0]     lo32, hi32, cnt32, ri32, tri32;
    logic [KW-1:0]   x1, x2;
    logic [2*KW-1:0] prod1, prod2;
    logic            tab_we;
    logic [KW-1:0]   tab_wa;
    logic [EW-1:0]   tab_wd, tab_rd;
    logic            t_used;
    logic [NW-1:0]   t_lo, t_hi;
    logic [TW-1:0]   t_tri;
    logic [1:0]      t_edge;
    logic            t_match;
    logic [3*NW-1:0] tri_rd;
    logic [BW-1:0]   nb_wd, nb_rd;
    logic [12:0]     total_sum;
    logic [11:0]     total_next;
    logic            rd_ok_next;

    assign cnt32 = 32'(cnt_reg);
    assign ri32  = 32'(read_index);
    assign tri32 = 32'(tri_reg);

    // Edge end points in ascending order.
    always_comb
    begin
        case (edge_reg)
            EDGE_BC:
            begin
                p_n = b_reg;
                q_n = c_reg;
            end
            EDGE_CA:
            begin
                p_n = c_reg;
                q_n = a_reg;
            end
            EDGE_AB:
            begin
                p_n = a_reg;
                q_n = b_reg;
            end
            default:
            begin
                p_n = a_reg;
                q_n = b_reg;
            end
        endcase
        lo_next = (p_n < q_n) ? p_n : q_n;
        hi_next = (p_n < q_n) ? q_n : p_n;
    end

    // Two hash rounds, one multiplier each, registered in between.
    // The slot only needs the low bits, so the operands are table-width.
    assign lo32  = 32'(lo_next);
    assign hi32  = 32'(hi_reg);
    assign x1    = BASIS_K ^ lo32[KW-1:0];
    assign x2    = h_reg ^ hi32[KW-1:0];
    assign prod1 = {{KW{1'b0}}, x1} * {{KW{1'b0}}, PRIME_K};
    assign prod2 = {{KW{1'b0}}, x2} * {{KW{1'b0}}, PRIME_K};

    // Edge table entry decode.
    assign t_used  = tab_rd[EW-1];
    assign t_lo    = tab_rd[EW-2 -: NW];
    assign t_hi    = tab_rd[EW-2-NW -: NW];
    assign t_tri   = tab_rd[TW+1:2];
    assign t_edge  = tab_rd[1:0];
    assign t_match = t_used && (t_lo == lo_reg) && (t_hi == hi_reg) && (t_tri != tri_reg);

    assign tab_we = ctl.clr_step || ctl.insert;
    assign tab_wa = ctl.clr_step ? clr_reg : idx_reg;
    assign tab_wd = ctl.clr_step ? '0 : {1'b1, lo_reg, hi_reg, tri_reg, edge_reg};

    tenf_ram #(.WIDTH(EW), .DEPTH(HASH_SLOTS)) u_edge_ram (
        .clk     (clk),
        .we      (tab_we),
        .wr_addr (tab_wa),
        .wr_data (tab_wd),
        .rd_addr (idx_reg),
        .rd_data (tab_rd)
    );

    tenf_ram #(.WIDTH(3 * NW), .DEPTH(MAX_TRIANGLES)) u_tri_ram (
        .clk     (clk),
        .we      (ctl.store_tri),
        .wr_addr (tri_reg),
        .wr_data ({a_reg, b_reg, c_reg}),
        .rd_addr (tri_reg),
        .rd_data (tri_rd)
    );

    assign nb_wd = {nbf_reg[2], nbt_reg[2], nbe_reg[2],
                    nbf_reg[1], nbt_reg[1], nbe_reg[1],
                    nbf_reg[0], nbt_reg[0], nbe_reg[0], bc_reg};

    tenf_ram #(.WIDTH(BW), .DEPTH(MAX_TRIANGLES)) u_nb_ram (
        .clk     (clk),
        .we      (ctl.tri_end),
        .wr_addr (tri_reg),
        .wr_data (nb_wd),
        .rd_addr (rd_addr_reg),
        .rd_data (nb_rd)
    );

    // Saturating whole-mesh boundary total.
    assign total_sum  = {1'b0, total_reg} + 13'(bc_reg);
    assign total_next = total_sum[12] ? TOTAL_MAX : total_sum[11:0];
    assign rd_ok_next = done_reg && (ri32 < cnt32);

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            total_reg     <= '0;
            done_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (ctl.insert)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (ctl.store_tri)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (ctl.b_init)
            begin
                total_reg <= '0;
            end
            else if (ctl.tri_end)
            begin
                total_reg <= total_next;
            end
            if (ctl.set_done)
            begin
                done_reg <= 1'b1;
            end
            if (ctl.set_ovf)
            begin
                ovf_reg <= 1'b1;
            end
            if (ctl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers.
    always_ff @(posedge clk)
    begin
        if (ctl.cap_in)
        begin
            a_reg    <= node_a[NW-1:0];
            b_reg    <= node_b[NW-1:0];
            c_reg    <= node_c[NW-1:0];
            last_reg <= last_triangle;
            tri_reg  <= cnt32[TW-1:0];
            edge_reg <= EDGE_BC;
        end
        if (ctl.cap_tri)
        begin
            a_reg    <= tri_rd[3*NW-1 -: NW];
            b_reg    <= tri_rd[2*NW-1 -: NW];
            c_reg    <= tri_rd[NW-1:0];
            edge_reg <= EDGE_BC;
            bc_reg   <= '0;
        end
        if (ctl.b_init)
        begin
            tri_reg <= '0;
        end
        if (ctl.tri_inc)
        begin
            tri_reg <= tri_reg + 1'b1;
        end
        if (ctl.edge_inc)
        begin
            edge_reg <= edge_reg + 1'b1;
        end
        if (ctl.hash_a)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            h_reg  <= prod1[KW-1:0];
        end
        if (ctl.hash_b)
        begin
            idx_reg           <= prod2[KW-1:0];
            step_reg          <= '0;
            nbf_reg[edge_reg] <= 1'b0;
        end
        if (ctl.idx_inc)
        begin
            idx_reg  <= idx_reg + 1'b1;
            step_reg <= step_reg + 1'b1;
        end
        // Later matches along the chain overwrite earlier ones.
        if (ctl.record && t_match)
        begin
            nbf_reg[edge_reg] <= 1'b1;
            nbt_reg[edge_reg] <= t_tri;
            nbe_reg[edge_reg] <= t_edge;
        end
        if (ctl.bc_inc && !nbf_reg[edge_reg])
        begin
            bc_reg <= bc_reg + 1'b1;
        end
        if (ctl.cap_rd)
        begin
            rd_addr_reg <= ri32[TW-1:0];
            ok_reg      <= rd_ok_next;
        end
    end

    // Result register, filled from the neighbour store and the mesh totals of the read.
    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            res_ok_reg    <= ok_reg;
            bc_out_reg    <= ok_reg ? nb_rd[1:0] : 2'd0;
            total_out_reg <= total_reg;
            ovf_out_reg   <= ovf_reg;
            for (int i = 0; i < 3; i++)
            begin
                if (ok_reg && nb_rd[2 + i * FW + FW - 1])
                begin
                    nb_out_reg[i] <= 11'(32'(nb_rd[2 + i * FW + 2 +: TW]));
                    ne_out_reg[i] <= {1'b0, nb_rd[2 + i * FW +: 2]};
                end
                else
                begin
                    nb_out_reg[i] <= '1;
                    ne_out_reg[i] <= '1;
                end
            end
        end
    end

    assign sts.clr_last  = (clr_reg == SLOT_LAST);
    assign sts.tab_full  = (32'(fill_reg) >= 32'(HASH_SLOTS));
    assign sts.tab_used  = t_used;
    assign sts.step_last = (step_reg == SLOT_LAST);
    assign sts.cnt_full  = (cnt32 == 32'(MAX_TRIANGLES));
    assign sts.cnt_zero  = (cnt_reg == '0);
    assign sts.last_flag = last_reg;
    assign sts.edge_last = (edge_reg == EDGE_AB);
    assign sts.tri_last  = ((tri32 + 32'd1) == cnt32);
    assign sts.done      = done_reg;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid        = out_valid_reg;
    assign result_valid     = res_ok_reg;
    assign neighbour_0      = nb_out_reg[0];
    assign neighbour_1      = nb_out_reg[1];
    assign neighbour_2      = nb_out_reg[2];
    assign neighbour_edge_0 = ne_out_reg[0];
    assign neighbour_edge_1 = ne_out_reg[1];
    assign neighbour_edge_2 = ne_out_reg[2];
    assign open_edge_count  = bc_out_reg;
    assign total_boundaries = total_out_reg;
    assign load_overflow    = ovf_out_reg;

endmodule

@@ test/tb_triangle_edge_neighbour_finder_core.sv @@
`timescale 1ns / 100ps

module tb_triangle_edge_neighbour_finder_core;
    import tenf_pkg::*;

    localparam int MESH_CAP    = 1024;
    localparam int SLOTS       = 16384;
    localparam int CYCLE_LIMIT = 1000000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic               action;
    logic [15:0]        node_a;
    logic [15:0]        node_b;
    logic [15:0]        node_c;
    logic               last_triangle;
    logic [9:0]         read_index;
    logic               out_valid;
    logic               out_stall;
    logic               result_valid;
    logic signed [10:0] neighbour_0;
    logic signed [10:0] neighbour_1;
    logic signed [10:0] neighbour_2;
    logic signed [2:0]  neighbour_edge_0;
    logic signed [2:0]  neighbour_edge_1;
    logic signed [2:0]  neighbour_edge_2;
    logic [1:0]         open_edge_count;
    logic [11:0]        total_boundaries;
    logic               load_overflow;

    triangle_edge_neighbour_finder_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .node_a           (node_a),
        .node_b           (node_b),
        .node_c           (node_c),
        .last_triangle    (last_triangle),
        .read_index       (read_index),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result_valid     (result_valid),
        .neighbour_0      (neighbour_0),
        .neighbour_1      (neighbour_1),
        .neighbour_2      (neighbour_2),
        .neighbour_edge_0 (neighbour_edge_0),
        .neighbour_edge_1 (neighbour_edge_1),
        .neighbour_edge_2 (neighbour_edge_2),
        .open_edge_count  (open_edge_count),
        .total_boundaries (total_boundaries),
        .load_overflow    (load_overflow)
    );

    // One expected read result.
    typedef struct {
        logic               ok;
        logic signed [10:0] nb [3];
        logic signed [2:0]  nb_edge [3];
        logic [1:0]         bcount;
        logic [11:0]        total;
        logic               ovf;
    } read_result_t;

    read_result_t pending_reads[$];

    // Own copy of the mesh, the edge table and the neighbour results.
    logic [15:0] mesh_nodes [MESH_CAP][3];
    int          mesh_nb [MESH_CAP][3];
    int          mesh_nb_edge [MESH_CAP][3];
    int          mesh_bcount [MESH_CAP];
    logic [15:0] slot_lo [SLOTS];
    logic [15:0] slot_hi [SLOTS];
    int          slot_tri [SLOTS];
    int          slot_edge [SLOTS];
    bit          slot_used [SLOTS];
    int          slots_filled;
    int          mesh_count;
    int          mesh_total;
    bit          mesh_built;
    bit          mesh_overflow;

    int  sender_idle;
    int  receiver_idle;
    int  accepted;
    int  cycles;
    bit  failed;

    // Clock and reset.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Edge table slot from the FNV-1a hash of the ordered pair.
    function automatic int edge_slot(logic [15:0] lo, logic [15:0] hi);
        logic [63:0] h;
        h = FNV_BASIS;
        h = h ^ {48'd0, lo};
        h = h * FNV_PRIME;
        h = h ^ {48'd0, hi};
        h = h * FNV_PRIME;
        return int'(h % SLOTS);
    endfunction

    task automatic edge_key(input int t, input int e, output logic [15:0] lo,
                            output logic [15:0] hi);
        logic [15:0] p;
        logic [15:0] q;
        p = (e == EDGE_BC) ? mesh_nodes[t][1] : (e == EDGE_CA) ? mesh_nodes[t][2]
                                                                : mesh_nodes[t][0];
        q = (e == EDGE_BC) ? mesh_nodes[t][2] : (e == EDGE_CA) ? mesh_nodes[t][0]
                                                                : mesh_nodes[t][1];
        lo = (p < q) ? p : q;
        hi = (p < q) ? q : p;
    endtask

    // Neighbour search over every stored triangle.
    task automatic build_neighbours();
        logic [15:0] lo;
        logic [15:0] hi;
        int          idx;
        int          cnt;
        mesh_total = 0;
        for (int t = 0; t < mesh_count; t++)
        begin
            cnt = 0;
            for (int e = 0; e < 3; e++)
            begin
                mesh_nb[t][e] = -1;
                mesh_nb_edge[t][e] = -1;
                edge_key(t, e, lo, hi);
                idx = edge_slot(lo, hi);
                for (int s = 0; s < SLOTS && slot_used[idx]; s++)
                begin
                    if (slot_lo[idx] == lo && slot_hi[idx] == hi && slot_tri[idx] != t)
                    begin
                        mesh_nb[t][e] = slot_tri[idx];
                        mesh_nb_edge[t][e] = slot_edge[idx];
                    end
                    idx = (idx + 1) % SLOTS;
                end
                if (mesh_nb[t][e] < 0)
                    cnt++;
            end
            mesh_bcount[t] = cnt;
            mesh_total = (mesh_total + cnt > 4095) ? 4095 : mesh_total + cnt;
        end
        mesh_built = 1'b1;
    endtask

    // Applies one accepted transfer to the mesh and queues any read result.
    task automatic mesh_apply(logic act, logic [15:0] a, logic [15:0] b, logic [15:0] c,
                              logic last, logic [9:0] idx);
        logic [15:0]  lo;
        logic [15:0]  hi;
        int           slot;
        read_result_t r;
        if (act == ACT_LOAD)
        begin
            if (mesh_built)
                return;
            if (mesh_count < MESH_CAP)
            begin
                mesh_nodes[mesh_count][0] = a;
                mesh_nodes[mesh_count][1] = b;
                mesh_nodes[mesh_count][2] = c;
                for (int e = 0; e < 3; e++)
                begin
                    if (slots_filled < SLOTS)
                    begin
                        edge_key(mesh_count, e, lo, hi);
                        slot = edge_slot(lo, hi);
                        while (slot_used[slot])
                            slot = (slot + 1) % SLOTS;
                        slot_lo[slot] = lo;
                        slot_hi[slot] = hi;
                        slot_tri[slot] = mesh_count;
                        slot_edge[slot] = e;
                        slot_used[slot] = 1'b1;
                        slots_filled++;
                    end
                end
                mesh_count++;
            end
            else
                mesh_overflow = 1'b1;
            if (last)
                build_neighbours();
            return;
        end
        r.ok = mesh_built && (idx < mesh_count);
        for (int e = 0; e < 3; e++)
        begin
            r.nb[e] = r.ok ? 11'(mesh_nb[idx][e]) : -11'sd1;
            r.nb_edge[e] = r.ok ? 3'(mesh_nb_edge[idx][e]) : -3'sd1;
        end
        r.bcount = r.ok ? 2'(mesh_bcount[idx]) : 2'd0;
        r.total = 12'(mesh_total);
        r.ovf = mesh_overflow;
        pending_reads.push_back(r);
    endtask

    // Drives one item and holds it until the transfer happens.
    task automatic send_item(logic act, logic [15:0] a, logic [15:0] b, logic [15:0] c,
                             logic last, logic [9:0] idx);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        node_a <= a;
        node_b <= b;
        node_c <= c;
        last_triangle <= last;
        read_index <= idx;
        do
            @(posedge clk);
        while (in_stall);
        mesh_apply(act, a, b, c, last, idx);
        accepted++;
        if (accepted == 500)
        begin
            sender_idle = 85;
            receiver_idle = 29;
        end
        else if (accepted == 1000)
        begin
            sender_idle = 0;
            receiver_idle = 0;
        end
    endtask

    task automatic send_load(logic [15:0] a, logic [15:0] b, logic [15:0] c, logic last);
        send_item(ACT_LOAD, a, b, c, last, 10'($urandom));
    endtask

    task automatic send_read(logic [9:0] idx);
        send_item(ACT_READ, 16'($urandom), 16'($urandom), 16'($urandom), 1'b0, idx);
    endtask

    // Receiver stalls at random.
    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < receiver_idle);
    end

    task automatic compare_field(string name, int exp_v, int act_v);
        if (exp_v != act_v)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
            failed = 1'b1;
        end
    endtask

    // Each result transfer is checked against the oldest expectation.
    always @(posedge clk)
    begin
        read_result_t r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reads.size() == 0)
            begin
                $display("%0t: result transfer with none expected", $time);
                failed = 1'b1;
            end
            else
            begin
                r = pending_reads.pop_front();
                compare_field("result_valid", r.ok, result_valid);
                compare_field("neighbour_0", r.nb[0], neighbour_0);
                compare_field("neighbour_1", r.nb[1], neighbour_1);
                compare_field("neighbour_2", r.nb[2], neighbour_2);
                compare_field("neighbour_edge_0", r.nb_edge[0], neighbour_edge_0);
                compare_field("neighbour_edge_1", r.nb_edge[1], neighbour_edge_1);
                compare_field("neighbour_edge_2", r.nb_edge[2], neighbour_edge_2);
                compare_field("open_edge_count", r.bcount, open_edge_count);
                compare_field("total_boundaries", r.total, total_boundaries);
                compare_field("load_overflow", r.ovf, load_overflow);
            end
        end
    end

    // Reads before the build, shared edges, degenerate triangles and extreme ids.
    task automatic test_directed();
        send_read(10'd0);
        send_read(10'd1023);
        send_load(16'd0, 16'd1, 16'd2, 1'b0);
        send_load(16'd2, 16'd1, 16'd3, 1'b0);
        send_load(16'd1, 16'd2, 16'd7, 1'b0);
        send_load(16'hFFFF, 16'd0, 16'hFFFF, 1'b0);
        send_load(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        send_load(16'd0, 16'hFFFF, 16'd9, 1'b0);
        send_read(10'd0);
        send_read(10'd5);
        send_read(10'd6);
        // Hold off until every result has come back.
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
    endtask

    // Random mesh: most triangles reuse an edge of a recent one, reads mixed in.
    task automatic test_random_mesh();
        int          t;
        int          e;
        logic [15:0] p;
        logic [15:0] q;
        logic [15:0] fresh;
        while (mesh_count < MESH_CAP)
        begin
            if ($urandom_range(0, 99) < 22)
            begin
                send_read($urandom_range(0, 3) == 0 ? 10'($urandom)
                                                    : 10'($urandom_range(0, mesh_count)));
                continue;
            end
            fresh = 16'($urandom);
            if ($urandom_range(0, 99) < 10)
                send_load(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);
            else if ($urandom_range(0, 99) < 5)
                send_load(fresh, fresh, 16'($urandom), 1'b0);
            else
            begin
                t = mesh_count - 1 - $urandom_range(0, (mesh_count < 20) ? mesh_count - 1 : 19);
                e = $urandom_range(0, 2);
                p = mesh_nodes[t][(e + 1) % 3];
                q = mesh_nodes[t][(e + 2) % 3];
                if ($urandom_range(0, 1))
                    send_load(q, p, fresh, 1'b0);
                else
                    send_load(fresh, p, q, 1'b0);
            end
        end
    endtask

    // Loads beyond capacity; the dropped last one still starts the build.
    task automatic test_overflow_and_build();
        send_load(16'd11, 16'd12, 16'd13, 1'b0);
        send_load(16'd14, 16'd15, 16'd16, 1'b0);
        send_load(16'd11, 16'd12, 16'd13, 1'b1);
    endtask

    // Reads of the finished mesh, with ignored loads mixed in.
    task automatic test_reads_after_build();
        for (int i = 0; i < 230; i++)
        begin
            if ($urandom_range(0, 99) < 6)
                send_load(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
            else
                send_read(10'($urandom));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        action = ACT_LOAD;
        node_a = '0;
        node_b = '0;
        node_c = '0;
        last_triangle = 1'b0;
        read_index = '0;
        cycles = 0;
        failed = 1'b0;
        accepted = 0;
        sender_idle = 29;
        receiver_idle = 85;
        mesh_count = 0;
        mesh_total = 0;
        mesh_built = 1'b0;
        mesh_overflow = 1'b0;
        slots_filled = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_mesh();
        test_overflow_and_build();
        test_reads_after_build();

        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_reads.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (!failed)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
